// ----- sv/tbeq_pkg.sv -----
package tbeq_pkg;

  localparam int unsigned POLE_W     = 32;
  localparam int unsigned DIFF_W     = 33;
  localparam int unsigned COEF_W     = 17;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned MOP_W      = 18;
  localparam int unsigned PROD_W     = 51;
  localparam int unsigned RND_W      = 52;
  localparam int unsigned ACC_W      = 53;
  localparam int unsigned COEF_SHIFT = 16;
  localparam int unsigned GAIN_SHIFT = 12;
  localparam int unsigned STEP_W     = RND_W - COEF_SHIFT;
  localparam int unsigned TOT_W      = STEP_W + 1;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PIDX_W     = 3;
  localparam int unsigned DIDX_W     = 2;
  localparam int unsigned PC_W       = 5;

  typedef logic signed [POLE_W-1:0] pole_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [MOP_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [STEP_W-1:0] step_t;
  typedef logic signed [TOT_W-1:0]  tot_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam rnd_t  COEF_RND = rnd_t'(1) <<< (COEF_SHIFT - 1);
  localparam pole_t POLE_MAX = 32'sh7fffffff;
  localparam pole_t POLE_MIN = 32'sh80000000;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN = 3'd4;

  localparam logic [COEF_W-1:0] LOW_COEF_RST  = 17'd7545;
  localparam logic [COEF_W-1:0] HIGH_COEF_RST = 17'd42775;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd4096;

  localparam logic LANE_LO = 1'b0;
  localparam logic LANE_HI = 1'b1;

  localparam logic [DIDX_W-1:0] DLY_LAST  = 2'd2;
  localparam logic [DIDX_W-1:0] FILL_FULL = 2'd3;

  localparam logic [PC_W-1:0] PC_START  = 5'd0;
  localparam logic [PC_W-1:0] FIN_STEP  = 5'd18;

  typedef enum logic [2:0] {
    MUL_NONE     = 3'd0,
    MUL_COEF_LO  = 3'd1,
    MUL_COEF_HI  = 3'd2,
    MUL_GAIN_LO  = 3'd3,
    MUL_GAIN_MID = 3'd4,
    MUL_GAIN_HI  = 3'd5
  } mul_op_e;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_NO_ITEM  = 2'd1,
    COND_OUT_BUSY = 2'd2
  } cond_e;

  typedef struct packed {
    logic              start;
    logic              rd_en;
    logic [PIDX_W-1:0] rd_idx;
    logic              ld_en;
    logic              ld_lane;
    mul_op_e           mul_op;
    logic              upd_en;
    logic [PIDX_W-1:0] upd_idx;
    logic              band;
    acc_op_e           acc_op;
    logic              fin;
    cond_e             cond;
    logic [PC_W-1:0]   tgt;
    logic              last;
  } ctl_t;

  function automatic logic [PIDX_W-1:0] pidx(input logic lane, input logic [1:0] stage);
    return {lane, stage};
  endfunction

  // low and high cascades interleaved on one multiplier, then the three gains
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '0;
    unique case (pc)
      5'd0: begin
        w.start = 1'b1; w.rd_en = 1'b1; w.rd_idx = pidx(LANE_LO, 2'd0);
        w.cond = COND_NO_ITEM; w.tgt = PC_START;
      end
      5'd1: begin
        w.ld_en = 1'b1; w.ld_lane = LANE_LO;
        w.rd_en = 1'b1; w.rd_idx = pidx(LANE_HI, 2'd0);
      end
      5'd2: begin
        w.mul_op = MUL_COEF_LO; w.ld_en = 1'b1; w.ld_lane = LANE_HI;
      end
      5'd3: begin
        w.upd_en = 1'b1; w.upd_idx = pidx(LANE_LO, 2'd0); w.mul_op = MUL_COEF_HI;
        w.rd_en = 1'b1; w.rd_idx = pidx(LANE_LO, 2'd1);
      end
      5'd4: begin
        w.ld_en = 1'b1; w.ld_lane = LANE_LO;
        w.upd_en = 1'b1; w.upd_idx = pidx(LANE_HI, 2'd0);
        w.rd_en = 1'b1; w.rd_idx = pidx(LANE_HI, 2'd1);
      end
      5'd5: begin
        w.mul_op = MUL_COEF_LO; w.ld_en = 1'b1; w.ld_lane = LANE_HI;
      end
      5'd6: begin
        w.upd_en = 1'b1; w.upd_idx = pidx(LANE_LO, 2'd1); w.mul_op = MUL_COEF_HI;
        w.rd_en = 1'b1; w.rd_idx = pidx(LANE_LO, 2'd2);
      end
      5'd7: begin
        w.ld_en = 1'b1; w.ld_lane = LANE_LO;
        w.upd_en = 1'b1; w.upd_idx = pidx(LANE_HI, 2'd1);
        w.rd_en = 1'b1; w.rd_idx = pidx(LANE_HI, 2'd2);
      end
      5'd8: begin
        w.mul_op = MUL_COEF_LO; w.ld_en = 1'b1; w.ld_lane = LANE_HI;
      end
      5'd9: begin
        w.upd_en = 1'b1; w.upd_idx = pidx(LANE_LO, 2'd2); w.mul_op = MUL_COEF_HI;
        w.rd_en = 1'b1; w.rd_idx = pidx(LANE_LO, 2'd3);
      end
      5'd10: begin
        w.ld_en = 1'b1; w.ld_lane = LANE_LO;
        w.upd_en = 1'b1; w.upd_idx = pidx(LANE_HI, 2'd2);
        w.rd_en = 1'b1; w.rd_idx = pidx(LANE_HI, 2'd3);
      end
      5'd11: begin
        w.mul_op = MUL_COEF_LO; w.ld_en = 1'b1; w.ld_lane = LANE_HI;
      end
      5'd12: begin
        w.upd_en = 1'b1; w.upd_idx = pidx(LANE_LO, 2'd3); w.mul_op = MUL_COEF_HI;
      end
      5'd13: begin
        w.upd_en = 1'b1; w.upd_idx = pidx(LANE_HI, 2'd3); w.mul_op = MUL_GAIN_LO;
      end
      5'd14: begin
        w.band = 1'b1; w.acc_op = ACC_LOAD;
      end
      5'd15: begin
        w.mul_op = MUL_GAIN_MID;
      end
      5'd16: begin
        w.mul_op = MUL_GAIN_HI; w.acc_op = ACC_ADD;
      end
      5'd17: begin
        w.acc_op = ACC_ADD;
      end
      5'd18: begin
        w.fin = 1'b1; w.cond = COND_OUT_BUSY; w.tgt = FIN_STEP; w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/tbeq_in_if.sv -----
interface tbeq_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    channel_index;
  logic signed [SAMPLE_BITS-1:0] input_sample;

  modport source (output valid, output channel_index, output input_sample, input ready);
  modport sink (input valid, input channel_index, input input_sample, output ready);
endinterface

// ----- sv/tbeq_out_if.sv -----
interface tbeq_out_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    channel_tag;
  logic signed [SAMPLE_BITS-1:0] output_sample;

  modport source (output valid, output channel_tag, output output_sample, input ready);
  modport sink (input valid, input channel_tag, input output_sample, output ready);
endinterface

// ----- sv/three_band_equalizer.sv -----
// one request at a time: ready is high only at the microcode program's start step;
//   the program runs eleven multiplies and the four-deep pole chain through one
//   18x33 multiplier and stalls at its last step while the output register is full
// a request whose channel index is CHANNELS or above is accepted and dropped
// reset (async, active low): program counter, output valid, per-channel fill counts
//   and config registers; stores of a channel read as zero until it has been written
module three_band_equalizer #(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  tbeq_in_if.sink                             in_req_i,
  tbeq_out_if.source                          out_req_o,
  input  logic                                cfg_we_i,
  input  logic [tbeq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tbeq_pkg::COEF_W-1:0]         cfg_wdata_i
);

  localparam int unsigned CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PA_W    = CH_AW + tbeq_pkg::PIDX_W;
  localparam int unsigned DA_W    = CH_AW + tbeq_pkg::DIDX_W;
  localparam int unsigned PMEM_D  = CHANNELS * (1 << tbeq_pkg::PIDX_W);
  localparam int unsigned DMEM_D  = CHANNELS * (1 << tbeq_pkg::DIDX_W);
  localparam int unsigned FRAC    = tbeq_pkg::POLE_W - SAMPLE_BITS;
  localparam int unsigned OUT_SH  = tbeq_pkg::GAIN_SHIFT + FRAC;

  localparam tbeq_pkg::acc_t OUT_RND = tbeq_pkg::acc_t'(1) <<< (OUT_SH - 1);
  localparam tbeq_pkg::acc_t OUT_MAX =
    (tbeq_pkg::acc_t'(1) <<< (SAMPLE_BITS - 1)) - tbeq_pkg::acc_t'(1);
  localparam tbeq_pkg::acc_t OUT_MIN = -OUT_MAX - tbeq_pkg::acc_t'(1);

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // program counter and control word
  logic [tbeq_pkg::PC_W-1:0] pc_q, pc_d;
  tbeq_pkg::ctl_t            ctl;

  // config
  logic [tbeq_pkg::COEF_W-1:0]        lo_coef_q, hi_coef_q;
  logic signed [tbeq_pkg::GAIN_W-1:0] gain_lo_q, gain_md_q, gain_hi_q;

  // handshake
  logic             accept, in_ch_ok, good, out_free, hold, fin_go;
  logic [CH_AW-1:0] in_ch_idx, ch_idx, rd_ch;

  // per-channel fill counts and delay pointers
  logic [tbeq_pkg::DIDX_W-1:0] ptr_q  [CHANNELS];
  logic [tbeq_pkg::DIDX_W-1:0] fill_q [CHANNELS];
  logic                        pvalid, dvalid;

  // stores
  tbeq_pkg::pole_t pole_mem [PMEM_D];
  smp_t            dly_mem  [DMEM_D];
  tbeq_pkg::pole_t prd_q, prd_eff;
  smp_t            drd_q, dly_eff;
  logic [PA_W-1:0] prd_addr, pwr_addr;
  logic [DA_W-1:0] drd_addr, dwr_addr;

  // datapath
  logic [tbeq_pkg::CHAN_W-1:0] chan_q;
  smp_t                        x_q;
  tbeq_pkg::pole_t             src_q [2];
  tbeq_pkg::pole_t             xs_in, dly_s, pole_q, ppole_q, newp;
  tbeq_pkg::diff_t             diff_q, mid_q, high_q, mul_b;
  tbeq_pkg::mop_t              mul_a;
  tbeq_pkg::prod_t             prod_q;
  tbeq_pkg::rnd_t              rnd_sum;
  tbeq_pkg::step_t             step_v;
  tbeq_pkg::tot_t              tot;
  logic [tbeq_pkg::TOT_W-tbeq_pkg::POLE_W:0] tot_top;
  tbeq_pkg::acc_t              acc_q, osum, ores, osat;

  // output register
  logic                        out_vld_q;
  logic [tbeq_pkg::CHAN_W-1:0] out_tag_q;
  smp_t                        out_smp_q;

  assign ctl = tbeq_pkg::ucode(pc_q);

  assign in_req_i.ready = (pc_q == tbeq_pkg::PC_START);
  assign accept         = in_req_i.valid & in_req_i.ready;
  assign in_ch_ok       = 32'(in_req_i.channel_index) < CHANNELS;
  assign good           = accept & in_ch_ok;
  assign out_free       = ~out_vld_q | out_req_o.ready;
  assign fin_go         = ctl.fin & out_free;

  assign in_ch_idx = CH_AW'(in_req_i.channel_index);
  assign ch_idx    = CH_AW'(chan_q);
  assign rd_ch     = ctl.start ? in_ch_idx : ch_idx;

  always_comb begin
    case (ctl.cond)
      tbeq_pkg::COND_NO_ITEM:  hold = ~good;
      tbeq_pkg::COND_OUT_BUSY: hold = ~out_free;
      default:                 hold = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_d = ctl.tgt;
    end else if (ctl.last) begin
      pc_d = tbeq_pkg::PC_START;
    end else begin
      pc_d = pc_q + tbeq_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tbeq_pkg::PC_START;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_coef_q <= tbeq_pkg::LOW_COEF_RST;
      hi_coef_q <= tbeq_pkg::HIGH_COEF_RST;
      gain_lo_q <= tbeq_pkg::GAIN_RST;
      gain_md_q <= tbeq_pkg::GAIN_RST;
      gain_hi_q <= tbeq_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbeq_pkg::CFG_LOW_COEF:  lo_coef_q <= cfg_wdata_i;
        tbeq_pkg::CFG_HIGH_COEF: hi_coef_q <= cfg_wdata_i;
        tbeq_pkg::CFG_LOW_GAIN:  gain_lo_q <= cfg_wdata_i[tbeq_pkg::GAIN_W-1:0];
        tbeq_pkg::CFG_MID_GAIN:  gain_md_q <= cfg_wdata_i[tbeq_pkg::GAIN_W-1:0];
        tbeq_pkg::CFG_HIGH_GAIN: gain_hi_q <= cfg_wdata_i[tbeq_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_q[i]  <= '0;
        fill_q[i] <= '0;
      end
    end else if (fin_go) begin
      ptr_q[ch_idx] <= (ptr_q[ch_idx] == tbeq_pkg::DLY_LAST) ? '0
                                                              : ptr_q[ch_idx] + 2'd1;
      if (fill_q[ch_idx] != tbeq_pkg::FILL_FULL) begin
        fill_q[ch_idx] <= fill_q[ch_idx] + 2'd1;
      end
    end
  end

  assign pvalid  = (fill_q[ch_idx] != '0);
  assign dvalid  = (fill_q[ch_idx] == tbeq_pkg::FILL_FULL);
  assign prd_eff = pvalid ? prd_q : '0;
  assign dly_eff = dvalid ? drd_q : '0;

  assign prd_addr = {rd_ch, ctl.rd_idx};
  assign pwr_addr = {ch_idx, ctl.upd_idx};
  assign drd_addr = {in_ch_idx, ptr_q[in_ch_idx]};
  assign dwr_addr = {ch_idx, ptr_q[ch_idx]};

  always_ff @(posedge clk_i) begin
    if (ctl.rd_en) begin
      prd_q <= pole_mem[prd_addr];
    end
    if (ctl.upd_en) begin
      pole_mem[pwr_addr] <= newp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.start) begin
      drd_q <= dly_mem[drd_addr];
    end
    if (fin_go) begin
      dly_mem[dwr_addr] <= x_q;
    end
  end

  assign xs_in = tbeq_pkg::pole_t'(in_req_i.input_sample) <<< FRAC;
  assign dly_s = tbeq_pkg::pole_t'(dly_eff) <<< FRAC;

  // pole step: round half up, saturate to 32 bits
  always_comb begin
    rnd_sum = tbeq_pkg::rnd_t'(prod_q) + tbeq_pkg::COEF_RND;
    step_v  = rnd_sum[tbeq_pkg::RND_W-1:tbeq_pkg::COEF_SHIFT];
    tot     = tbeq_pkg::tot_t'(ppole_q) + tbeq_pkg::tot_t'(step_v);
    tot_top = tot[tbeq_pkg::TOT_W-1:tbeq_pkg::POLE_W-1];
    if ((&tot_top) || (~|tot_top)) begin
      newp = tot[tbeq_pkg::POLE_W-1:0];
    end else if (tot[tbeq_pkg::TOT_W-1]) begin
      newp = tbeq_pkg::POLE_MIN;
    end else begin
      newp = tbeq_pkg::POLE_MAX;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul_op)
      tbeq_pkg::MUL_COEF_LO: begin
        mul_a = $signed({1'b0, lo_coef_q});
        mul_b = diff_q;
      end
      tbeq_pkg::MUL_COEF_HI: begin
        mul_a = $signed({1'b0, hi_coef_q});
        mul_b = diff_q;
      end
      tbeq_pkg::MUL_GAIN_LO: begin
        mul_a = tbeq_pkg::mop_t'(gain_lo_q);
        mul_b = tbeq_pkg::diff_t'(src_q[tbeq_pkg::LANE_LO]);
      end
      tbeq_pkg::MUL_GAIN_MID: begin
        mul_a = tbeq_pkg::mop_t'(gain_md_q);
        mul_b = mid_q;
      end
      tbeq_pkg::MUL_GAIN_HI: begin
        mul_a = tbeq_pkg::mop_t'(gain_hi_q);
        mul_b = high_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.start && good) begin
      chan_q <= in_req_i.channel_index;
      x_q    <= in_req_i.input_sample;
      src_q[tbeq_pkg::LANE_LO] <= xs_in;
      src_q[tbeq_pkg::LANE_HI] <= xs_in;
    end else if (ctl.upd_en) begin
      src_q[ctl.upd_idx[tbeq_pkg::PIDX_W-1]] <= newp;
    end
    if (ctl.ld_en) begin
      diff_q <= tbeq_pkg::diff_t'(src_q[ctl.ld_lane]) - tbeq_pkg::diff_t'(prd_eff);
      pole_q <= prd_eff;
    end
    if (ctl.mul_op != tbeq_pkg::MUL_NONE) begin
      prod_q  <= tbeq_pkg::prod_t'(mul_a) * tbeq_pkg::prod_t'(mul_b);
      ppole_q <= pole_q;
    end
    if (ctl.band) begin
      high_q <= tbeq_pkg::diff_t'(dly_s) - tbeq_pkg::diff_t'(src_q[tbeq_pkg::LANE_HI]);
      mid_q  <= tbeq_pkg::diff_t'(src_q[tbeq_pkg::LANE_HI])
              - tbeq_pkg::diff_t'(src_q[tbeq_pkg::LANE_LO]);
    end
    case (ctl.acc_op)
      tbeq_pkg::ACC_LOAD: acc_q <= tbeq_pkg::acc_t'(prod_q);
      tbeq_pkg::ACC_ADD:  acc_q <= acc_q + tbeq_pkg::acc_t'(prod_q);
      default: ;
    endcase
  end

  // output rounding and saturation
  always_comb begin
    osum = acc_q + OUT_RND;
    ores = osum >>> OUT_SH;
    if (ores > OUT_MAX) begin
      osat = OUT_MAX;
    end else if (ores < OUT_MIN) begin
      osat = OUT_MIN;
    end else begin
      osat = ores;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_go) begin
      out_vld_q <= 1'b1;
    end else if (out_req_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_tag_q <= chan_q;
      out_smp_q <= smp_t'(osat);
    end
  end

  assign out_req_o.valid         = out_vld_q;
  assign out_req_o.channel_tag   = out_tag_q;
  assign out_req_o.output_sample = out_smp_q;

`ifndef SYNTH
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(pc_q == tbeq_pkg::FIN_STEP))
    else $error("result loaded outside the final step");

  a_bad_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_ch_ok) |=> (pc_q == tbeq_pkg::PC_START))
    else $error("out-of-range channel started the program");

  a_good_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_ch_ok) |=> (pc_q == tbeq_pkg::PC_START + tbeq_pkg::PC_W'(1)))
    else $error("accepted request did not start the program");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= tbeq_pkg::FIN_STEP)
    else $error("program counter beyond the program");
`endif

endmodule

// ----- tb/three_band_equalizer_tb.sv -----
module three_band_equalizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS     = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int STAGES       = 4;
  localparam int DELAY_LEN    = 3;
  localparam int FRAC         = 32 - SAMPLE_BITS;
  localparam int IDLE_LIMIT   = 1000;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASES       = 12;
  localparam int SETTLE       = 40;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [tbeq_pkg::CHAN_W-1:0] chan_t;
  typedef logic [tbeq_pkg::COEF_W-1:0] wdata_t;

  typedef struct packed {
    chan_t   ch;
    sample_t y;
  } eq_out_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam wdata_t  COEF_MAX   = '1;
  localparam logic [tbeq_pkg::GAIN_W-1:0] GAIN_MAX = 16'h7fff;
  localparam logic [tbeq_pkg::GAIN_W-1:0] GAIN_MIN = 16'h8000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tbeq_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  wdata_t cfg_wdata = '0;

  tbeq_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_req ();
  tbeq_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_req ();

  three_band_equalizer #(
    .CHANNELS(CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_req_i(in_req),
    .out_req_o(out_req),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // filter state and settings as the block should hold them
  longint low_poles[CHANNELS][STAGES];
  longint high_poles[CHANNELS][STAGES];
  longint delay_line[CHANNELS][DELAY_LEN];
  longint low_coef, high_coef, lo_weight, md_weight, hi_weight;

  eq_out_t expected_samples[$];
  eq_out_t oldest;
  sample_t held[CHANNELS];

  int mismatches = 0;
  int idle_cycles = 0;
  int stall_pct = 0;
  int stall_max = 1;
  int stall_left = 0;
  int gap_max = 0;
  int burst_max = 1;
  int burst_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint saturate(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint advance_poles(bit hi_lane, int ch, longint x);
    longint src, coef, pole, step;
    src = x;
    coef = hi_lane ? high_coef : low_coef;
    for (int k = 0; k < STAGES; k++) begin
      pole = hi_lane ? high_poles[ch][k] : low_poles[ch][k];
      step = (coef * (src - pole) + (longint'(1) <<< (tbeq_pkg::COEF_SHIFT - 1)))
             >>> tbeq_pkg::COEF_SHIFT;
      pole = saturate(pole + step, tbeq_pkg::POLE_W);
      if (hi_lane) begin
        high_poles[ch][k] = pole;
      end else begin
        low_poles[ch][k] = pole;
      end
      src = pole;
    end
    return src;
  endfunction

  function automatic eq_out_t equalize(chan_t ch, sample_t x);
    longint xs, dly, low, high, mid, acc, y;
    eq_out_t r;
    xs = longint'(x) <<< FRAC;
    low = advance_poles(1'b0, int'(ch), xs);
    dly = delay_line[ch][DELAY_LEN-1] <<< FRAC;
    high = dly - advance_poles(1'b1, int'(ch), xs);
    mid = dly - (high + low);
    for (int k = DELAY_LEN - 1; k > 0; k--) begin
      delay_line[ch][k] = delay_line[ch][k-1];
    end
    delay_line[ch][0] = longint'(x);
    acc = lo_weight * low + md_weight * mid + hi_weight * high;
    y = (acc + (longint'(1) <<< (tbeq_pkg::GAIN_SHIFT + FRAC - 1)))
        >>> (tbeq_pkg::GAIN_SHIFT + FRAC);
    r.ch = ch;
    r.y = sample_t'(saturate(y, SAMPLE_BITS));
    return r;
  endfunction

  task automatic reset_filter_state();
    foreach (low_poles[c, k]) begin
      low_poles[c][k] = 0;
      high_poles[c][k] = 0;
    end
    foreach (delay_line[c, k]) delay_line[c][k] = 0;
    low_coef = longint'(tbeq_pkg::LOW_COEF_RST);
    high_coef = longint'(tbeq_pkg::HIGH_COEF_RST);
    lo_weight = longint'($signed(tbeq_pkg::GAIN_RST));
    md_weight = longint'($signed(tbeq_pkg::GAIN_RST));
    hi_weight = longint'($signed(tbeq_pkg::GAIN_RST));
  endtask

  task automatic write_reg(logic [tbeq_pkg::CFG_IDX_W-1:0] idx, wdata_t data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbeq_pkg::CFG_LOW_COEF:  low_coef = longint'(data);
      tbeq_pkg::CFG_HIGH_COEF: high_coef = longint'(data);
      tbeq_pkg::CFG_LOW_GAIN:  lo_weight = longint'($signed(data[tbeq_pkg::GAIN_W-1:0]));
      tbeq_pkg::CFG_MID_GAIN:  md_weight = longint'($signed(data[tbeq_pkg::GAIN_W-1:0]));
      tbeq_pkg::CFG_HIGH_GAIN: hi_weight = longint'($signed(data[tbeq_pkg::GAIN_W-1:0]));
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(wdata_t lc, wdata_t hc, wdata_t lg, wdata_t mg, wdata_t hg);
    write_reg(tbeq_pkg::CFG_LOW_COEF, lc);
    write_reg(tbeq_pkg::CFG_HIGH_COEF, hc);
    write_reg(tbeq_pkg::CFG_LOW_GAIN, lg);
    write_reg(tbeq_pkg::CFG_MID_GAIN, mg);
    write_reg(tbeq_pkg::CFG_HIGH_GAIN, hg);
  endtask

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_sample(chan_t ch, sample_t x);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_req.valid <= 1'b0;
        repeat ($urandom_range(gap_max, 1)) @(negedge clk);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    burst_left--;
    in_req.valid <= 1'b1;
    in_req.channel_index <= ch;
    in_req.input_sample <= x;
    do begin
      @(posedge clk);
    end while (!in_req.ready);
    expected_samples.push_back(equalize(ch, x));
    @(negedge clk);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    burst_left = 0;
    do begin
      @(negedge clk);
    end while (expected_samples.size() != 0);
  endtask

  task automatic set_idling(int gap, int burst, int pct, int stall);
    gap_max = gap;
    burst_max = burst;
    stall_pct = pct;
    stall_max = stall;
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%s", msg);
  endtask

  function automatic sample_t pick_sample(chan_t ch);
    case ($urandom_range(9, 0)) inside
      [0:3]: return sample_t'($urandom);
      4: begin
        case ($urandom_range(3, 0))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      [5:6]: return sample_t'(int'($urandom_range(2048, 0)) - 1024);
      default: begin
        if ($urandom_range(15, 0) == 0) held[ch] = sample_t'($urandom);
        return held[ch];
      end
    endcase
  endfunction

  function automatic wdata_t pick_coef();
    case ($urandom_range(5, 0))
      0: return COEF_MAX;
      1: return '0;
      2: return wdata_t'($urandom);
      default: return wdata_t'($urandom_range(65536, 0));
    endcase
  endfunction

  function automatic wdata_t pick_gain();
    logic [tbeq_pkg::GAIN_W-1:0] g;
    case ($urandom_range(5, 0))
      0: g = GAIN_MAX;
      1: g = GAIN_MIN;
      2: g = '0;
      3: g = tbeq_pkg::GAIN_W'($urandom);
      default: g = tbeq_pkg::GAIN_W'($urandom_range(8192, 0));
    endcase
    return {1'($urandom), g};
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_req.ready <= 1'b0;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      stall_left = $urandom_range(stall_max, 1) - 1;
      out_req.ready <= 1'b0;
    end else begin
      out_req.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_req.valid && out_req.ready) begin
      if (expected_samples.size() == 0) begin
        note_mismatch($sformatf("unexpected result: channel %0d, sample %0d",
                                out_req.channel_tag, out_req.output_sample));
      end else begin
        oldest = expected_samples.pop_front();
        if (out_req.channel_tag !== oldest.ch) begin
          note_mismatch($sformatf("channel_tag: expected %0d, got %0d",
                                  oldest.ch, out_req.channel_tag));
        end
        if (out_req.output_sample !== oldest.y) begin
          note_mismatch($sformatf("output_sample on channel %0d: expected %0d, got %0d",
                                  oldest.ch, oldest.y, out_req.output_sample));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_req.valid && out_req.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_default_settings();
    set_idling(0, 1, 0, 1);
    send_sample(3'd0, SAMPLE_MAX);
    send_sample(3'd0, SAMPLE_MAX);
    send_sample(3'd1, SAMPLE_MIN);
    send_sample(3'd7, SAMPLE_MIN);
    send_sample(3'd2, '0);
    send_sample(3'd3, '1);
    send_sample(3'd4, sample_t'(24'h555555));
    send_sample(3'd5, sample_t'(24'haaaaaa));
    drain();
  endtask

  // coefficients near two overshoot the poles into saturation
  task automatic test_extreme_settings();
    write_all(COEF_MAX, COEF_MAX, {1'b1, GAIN_MAX}, {1'b0, GAIN_MIN}, {1'b0, GAIN_MAX});
    set_idling(0, 1, 30, 4);
    for (int i = 0; i < 8; i++) begin
      send_sample(3'd6, i[0] ? SAMPLE_MIN : SAMPLE_MAX);
    end
    drain();
    write_all('0, '0, {1'b0, GAIN_MIN}, {1'b1, GAIN_MIN}, {1'b0, GAIN_MIN});
    send_sample(3'd6, SAMPLE_MAX);
    send_sample(3'd6, SAMPLE_MIN);
    send_sample(3'd7, SAMPLE_MAX);
    send_sample(3'd6, '0);
    drain();
  endtask

  task automatic test_spare_registers();
    for (int i = int'(tbeq_pkg::CFG_HIGH_GAIN) + 1; i < (1 << tbeq_pkg::CFG_IDX_W); i++) begin
      write_reg(tbeq_pkg::CFG_IDX_W'(i), wdata_t'($urandom));
    end
    for (int i = 0; i < 3; i++) begin
      send_sample(3'd6, sample_t'($urandom));
    end
    drain();
  endtask

  task automatic test_random_settings();
    int items;
    items = RANDOM_ITEMS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_all(tbeq_pkg::LOW_COEF_RST, tbeq_pkg::HIGH_COEF_RST,
                    {1'b0, tbeq_pkg::GAIN_RST}, {1'b0, tbeq_pkg::GAIN_RST},
                    {1'b0, tbeq_pkg::GAIN_RST});
          set_idling(0, 1, 0, 1);
        end
        1: begin
          write_all(COEF_MAX, '0, {1'b0, GAIN_MAX}, {1'b0, GAIN_MAX}, {1'b0, GAIN_MAX});
          set_idling(3, 8, 20, 5);
        end
        2: begin
          write_all('0, COEF_MAX, {1'b1, GAIN_MIN}, {1'b0, GAIN_MIN}, {1'b1, GAIN_MIN});
          set_idling(40, 30, 60, 40);
        end
        default: begin
          write_all(pick_coef(), pick_coef(), pick_gain(), pick_gain(), pick_gain());
          case ($urandom_range(2, 0))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 40;
          endcase
          burst_max = $urandom_range(30, 1);
          case ($urandom_range(2, 0))
            0: stall_pct = 0;
            1: stall_pct = 20;
            default: stall_pct = 60;
          endcase
          stall_max = $urandom_range(40, 1);
        end
      endcase
      for (int i = 0; i < items; i++) begin
        if (i == items / 2 && p % 3 == 1) drain();
        begin
          chan_t ch;
          ch = chan_t'($urandom_range(CHANNELS - 1, 0));
          send_sample(ch, pick_sample(ch));
        end
      end
      drain();
    end
  endtask

  initial begin
    in_req.valid = 1'b0;
    in_req.channel_index = '0;
    in_req.input_sample = '0;
    out_req.ready = 1'b0;
    foreach (held[c]) held[c] = '0;
    reset_filter_state();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_settings();
    test_extreme_settings();
    test_spare_registers();
    test_random_settings();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
